// ===== rtl/assert_macros.svh =====
// assertion helpers shared by lgs_front, lgs_cmd_queue and lgs_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/lgs_pkg.sv =====
`timescale 1ns / 1ps
package lgs_pkg;

    localparam int COL_W       = 6;
    localparam int ROWS_W      = 11;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b1;

    typedef logic [COL_W-1:0] t_col;

    typedef struct packed {
        logic alive;
        t_col col;
        logic row_end;
        logic has_above;
        logic last_row;
    } t_cmd;

    function automatic logic life_next(input logic [2:0] up, input logic [2:0] mid,
                                       input logic [2:0] low);
        logic [3:0] n;
        n = 4'(up[0]) + 4'(up[1]) + 4'(up[2]) + 4'(mid[0]) + 4'(mid[2])
            + 4'(low[0]) + 4'(low[1]) + 4'(low[2]);
        return (n == 4'd3) || ((n == 4'd2) && mid[1]);
    endfunction

endpackage

// ===== rtl/lgs_front.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lgs_front #(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic [$clog2(MAX_ROWS+1)-1:0]  i_rows,
    input  lgs_pkg::t_col                  i_cols,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_cell,
    input  logic                           i_full,
    output logic                           o_push,
    output lgs_pkg::t_cmd                  o_cmd
);
    import lgs_pkg::*;

    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int RCW = $clog2(MAX_ROWS+1);

    logic [CW-1:0]  r_col, n_col;
    logic [RW-1:0]  r_row, n_row;
    logic [CW-1:0]  c;
    logic           row_end;
    logic           last_row;
    logic [RCW-1:0] row_count;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        c = (t_col'(r_col) >= i_cols) ? CW'(i_cols - t_col'(1)) : r_col;
        row_end   = (t_col'(c) == (i_cols - t_col'(1)));
        row_count = RCW'(r_row) + RCW'(1);
        last_row  = (row_count >= i_rows);

        o_cmd.alive     = i_cell;
        o_cmd.col       = t_col'(c);
        o_cmd.row_end   = row_end;
        o_cmd.has_above = (r_row != '0);
        o_cmd.last_row  = last_row;

        n_col = r_col;
        n_row = r_row;
        if (o_push) begin
            if (row_end) begin
                n_col = '0;
                n_row = last_row ? '0 : RW'(row_count);
            end else begin
                n_col = c + CW'(1);
            end
        end
        if (i_clear) begin
            n_col = '0;
            n_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    `ASSERT_ALWAYS(a_col_in_range, i_clk, i_rst_n, t_col'(r_col) < i_cols, "column position past grid")
    `ASSERT_IMPLY(a_row_wrap, i_clk, i_rst_n, o_push && row_end && !i_clear, n_col == '0, "row end must return column to zero")

endmodule

// ===== rtl/lgs_cmd_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lgs_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_push,
    input  lgs_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output lgs_pkg::t_cmd o_cmd
);
    import lgs_pkg::*;

    t_cmd                   r_slot [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr, r_rd;
    logic [QUEUE_CNT_W-1:0] r_count;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QUEUE_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QUEUE_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QUEUE_CNT_W'(1);
                2'b01:   r_count <= r_count - QUEUE_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    `ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, i_push, !o_full || i_pop, "request pushed into full queue")
    `ASSERT_IMPLY(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")
    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

// ===== rtl/lgs_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lgs_back #(
    parameter int MAX_COLS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  lgs_pkg::t_col i_cols,
    input  logic          i_empty,
    input  lgs_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_next_alive,
    output logic          o_frame_end
);
    import lgs_pkg::*;

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int PW = $clog2(MAX_COLS+2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREV,
        ST_CUR,
        ST_SHIFT,
        ST_FLUSH
    } t_state;

    t_state              r_state, n_state;
    logic [MAX_COLS-1:0] r_upper, n_upper;
    logic [MAX_COLS-1:0] r_middle, n_middle;
    logic [MAX_COLS-1:0] r_incoming, n_incoming;
    t_cmd                r_cmd, n_cmd;
    logic [CW-1:0]       r_k, n_k;
    logic                r_out_valid, n_out_valid;
    logic                r_next_alive, n_next_alive;
    logic                r_frame_end, n_frame_end;

    logic                slot_free;
    logic [CW-1:0]       sel;
    logic [PW-1:0]       idx;
    logic [MAX_COLS+1:0] pad_up, pad_mid, pad_low;
    logic [2:0]          win_up, win_mid, win_low;
    logic                cell_next;
    logic                flush_last;

    assign o_valid      = r_out_valid;
    assign o_next_alive = r_next_alive;
    assign o_frame_end  = r_frame_end;
    assign o_pop        = (r_state == ST_IDLE) && !i_empty && !i_clear;
    assign slot_free    = !r_out_valid || !i_stall;
    assign flush_last   = (t_col'(r_k) == (i_cols - t_col'(1)));

    always_comb begin
        unique case (r_state)
            ST_PREV: sel = r_cmd.col[CW-1:0] - CW'(1);
            ST_CUR:  sel = r_cmd.col[CW-1:0];
            default: sel = r_k;
        endcase
        idx     = PW'(sel);
        pad_up  = {1'b0, r_upper, 1'b0};
        pad_mid = {1'b0, r_middle, 1'b0};
        pad_low = {1'b0, r_incoming, 1'b0};
        win_up  = pad_up[idx +: 3];
        win_mid = pad_mid[idx +: 3];
        win_low = (r_state == ST_FLUSH) ? 3'b000 : pad_low[idx +: 3];
        cell_next = life_next(win_up, win_mid, win_low);
    end

    always_comb begin
        n_state      = r_state;
        n_upper      = r_upper;
        n_middle     = r_middle;
        n_incoming   = r_incoming;
        n_cmd        = r_cmd;
        n_k          = r_k;
        n_out_valid  = r_out_valid;
        n_next_alive = r_next_alive;
        n_frame_end  = r_frame_end;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    n_incoming[i_cmd.col[CW-1:0]] = i_cmd.alive;
                    n_cmd = i_cmd;
                    if (i_cmd.has_above && (i_cmd.col != '0)) begin
                        n_state = ST_PREV;
                    end else if (i_cmd.has_above && i_cmd.row_end) begin
                        n_state = ST_CUR;
                    end else if (i_cmd.row_end) begin
                        n_state = ST_SHIFT;
                    end
                end
            end
            ST_PREV: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_next_alive = cell_next;
                    n_frame_end  = 1'b0;
                    n_state      = r_cmd.row_end ? ST_CUR : ST_IDLE;
                end
            end
            ST_CUR: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_next_alive = cell_next;
                    n_frame_end  = 1'b0;
                    n_state      = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                n_upper  = r_middle;
                n_middle = r_incoming;
                n_k      = '0;
                n_state  = r_cmd.last_row ? ST_FLUSH : ST_IDLE;
            end
            ST_FLUSH: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_next_alive = cell_next;
                    n_frame_end  = flush_last;
                    if (flush_last) begin
                        n_upper    = '0;
                        n_middle   = '0;
                        n_incoming = '0;
                        n_state    = ST_IDLE;
                    end else begin
                        n_k = r_k + CW'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (i_clear) begin
            n_state     = ST_IDLE;
            n_upper     = '0;
            n_middle    = '0;
            n_incoming  = '0;
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_upper     <= '0;
            r_middle    <= '0;
            r_incoming  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_upper     <= n_upper;
            r_middle    <= n_middle;
            r_incoming  <= n_incoming;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_k          <= n_k;
        r_next_alive <= n_next_alive;
        r_frame_end  <= n_frame_end;
    end

    `ASSERT_IMPLY(a_flush_col, i_clk, i_rst_n, r_state == ST_FLUSH, t_col'(r_k) < i_cols, "flush column past grid")
    `ASSERT_IMPLY(a_frame_end_src, i_clk, i_rst_n, $rose(r_out_valid && r_frame_end), $past(r_state) == ST_FLUSH, "frame end outside flush")

endmodule

// ===== rtl/life_generation_stencil.sv =====
// a 2-entry request queue sits in front of the back end, whose results are registered outputs
// the back end pops a new cell only when idle, once it has issued the results of the last one
// a row end adds states ST_CUR and ST_SHIFT (only ST_SHIFT on the first row)
// the last row then flushes one result per cycle per effective column unless the output stalls
// synchronous active-low reset clears row buffers, positions and queue; sizes reset to 2 x 2
`timescale 1ns / 1ps
module life_generation_stencil #(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lgs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lgs_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cell_alive,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_next_alive,
    output logic                          o_frame_end
);
    import lgs_pkg::*;

    localparam int RCW  = $clog2(MAX_ROWS+1);
    localparam int CMPW = ((RCW > ROWS_W) ? RCW : ROWS_W) + 1;

    logic [ROWS_W-1:0] r_grid_rows;
    t_col              r_grid_cols;
    logic [RCW-1:0]    eff_rows;
    t_col              eff_cols;
    logic [CMPW-1:0]   rows_ext;
    logic [COL_W:0]    cols_ext;

    logic push, pop, full, empty;
    t_cmd front_cmd, queue_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= ROWS_W'(2);
            r_grid_cols <= COL_W'(2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_ROWS: r_grid_rows <= i_cfg_data[ROWS_W-1:0];
                CFG_GRID_COLS: r_grid_cols <= i_cfg_data[COL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        rows_ext = CMPW'(r_grid_rows);
        if (rows_ext < CMPW'(2)) begin
            eff_rows = RCW'(2);
        end else if (rows_ext > CMPW'(MAX_ROWS)) begin
            eff_rows = RCW'(MAX_ROWS);
        end else begin
            eff_rows = RCW'(r_grid_rows);
        end

        cols_ext = (COL_W+1)'(r_grid_cols);
        if (cols_ext < (COL_W+1)'(2)) begin
            eff_cols = COL_W'(2);
        end else if (cols_ext > (COL_W+1)'(MAX_COLS)) begin
            eff_cols = COL_W'(MAX_COLS);
        end else begin
            eff_cols = r_grid_cols;
        end
    end

    lgs_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (i_cfg_we),
        .i_rows  (eff_rows),
        .i_cols  (eff_cols),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_cell  (i_cell_alive),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    lgs_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (i_cfg_we),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (queue_cmd)
    );

    lgs_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (i_cfg_we),
        .i_cols       (eff_cols),
        .i_empty      (empty),
        .i_cmd        (queue_cmd),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_next_alive (o_next_alive),
        .o_frame_end  (o_frame_end)
    );

endmodule
